[src/u8ks_pkg.sv]
// Shared types, constants and decode functions for the UTF-8 to keysym decoder.
// Used by every module of the block and by its port checker; depends on nothing.
package u8ks_pkg;

   localparam logic [24:0] TabKeysym   = 25'h00FF09;
   localparam logic [20:0] TabCodePt   = 21'h000009;
   localparam logic [20:0] FirstPrint  = 21'h000020;
   localparam logic [20:0] Latin1Limit = 21'h000100;
   localparam logic [3:0]  UnicodeHigh = 4'h8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [24:0] keysym;
      logic        tab_key;
      logic        run_last;
   } rsp_type;

   // One unit of work for the back end: the held bytes plus the new one.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
      logic            line_end;
   } job_type;

   // Sequence length announced by a lead byte; zero for a byte that cannot lead.
   function automatic logic [2:0] lead_length(input logic [7:0] c);
      logic [2:0] len;
      if (!c[7]) begin
         len = 3'd1;
      end else if (c[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (c[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (c[7:3] == 5'b11110) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   // Continuation bytes contribute their low six bits without any check.
   function automatic logic [20:0] decode_cp(input logic [3:0][7:0] w, input logic [2:0] len);
      logic [20:0] cp;
      case (len)
         3'd1:    cp = {13'd0, w[0]};
         3'd2:    cp = {10'd0, w[0][4:0], w[1][5:0]};
         3'd3:    cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
         default: cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
      endcase
      return cp;
   endfunction

   function automatic rsp_type make_word(input logic [20:0] cp);
      rsp_type w;
      w.run_last = 1'b0;
      if (cp == TabCodePt) begin
         w.keysym  = TabKeysym;
         w.tab_key = 1'b1;
      end else if (cp < Latin1Limit) begin
         w.keysym  = {4'd0, cp};
         w.tab_key = 1'b0;
      end else begin
         w.keysym  = {UnicodeHigh, cp};
         w.tab_key = 1'b0;
      end
      return w;
   endfunction

endpackage

[src/utf8_to_keysym_decoder.sv]
// The decoder takes one UTF-8 byte per cycle while its job queue has room and
// emits one keysym word per decoded character that is a tab or a printable
// code point. A byte that completes a character, cannot lead one, or ends a
// line becomes a job; the back end scans each job one position at a time,
// stepping over each character found and each byte skipped. Words wait in a
// one-word output register; the last word caused by a byte has run_last set.
// JobDepth sets how many jobs may wait between the halves.
// Top level; depends on u8ks_pkg, u8ks_front, u8ks_job_queue and u8ks_back.
module utf8_to_keysym_decoder #(
   parameter int unsigned JobDepth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  u8ks_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output u8ks_pkg::rsp_type rsp_data
);
   import u8ks_pkg::*;

   logic    q_push;
   logic    q_full;
   job_type q_push_data;
   logic    q_pop;
   logic    q_head_valid;
   job_type q_head_data;

   u8ks_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   u8ks_job_queue #(
      .Depth (JobDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   u8ks_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_head_valid),
      .job       (q_head_data),
      .job_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[src/u8ks_front.sv]
// Front end of the decoder: takes input bytes and gathers multi-byte sequences.
// Depends on u8ks_pkg; feeds jobs to u8ks_job_queue.
module u8ks_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  u8ks_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output u8ks_pkg::job_type q_data
);
   import u8ks_pkg::*;

   logic [7:0]      pend_bytes_ff [3];
   logic [7:0]      pend_bytes_in [3];
   logic [1:0]      pend_count_ff;
   logic [1:0]      pend_count_in;
   logic [3:0][7:0] gather;
   logic [2:0]      total;
   logic [2:0]      first_len;
   logic            accept;
   logic            hold;

   always_comb begin
      accept = req_push && !q_full;
      for (int k = 0; k < 3; k++) begin
         gather[k] = (2'(k) < pend_count_ff) ? pend_bytes_ff[k] : req_data.data_byte;
      end
      gather[3] = req_data.data_byte;
      total     = {1'b0, pend_count_ff} + 3'd1;
      first_len = lead_length(gather[0]);
      // An unfinished sequence waits here unless the line ends with it.
      hold      = !req_data.line_end && (total < first_len);

      q_data.bytes    = gather;
      q_data.count    = total;
      q_data.line_end = req_data.line_end;
      q_push          = accept && !hold;
      req_full        = q_full;

      pend_bytes_in = pend_bytes_ff;
      pend_count_in = pend_count_ff;
      if (accept) begin
         if (hold) begin
            for (int k = 0; k < 3; k++) begin
               pend_bytes_in[k] = gather[k];
            end
            pend_count_in = total[1:0];
         end else begin
            pend_count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_bytes_ff <= pend_bytes_in;
      if (reset) begin
         pend_count_ff <= 2'd0;
      end else begin
         pend_count_ff <= pend_count_in;
      end
   end

endmodule

[src/u8ks_job_queue.sv]
// Short register queue that parts the decoder front end from its back end.
// Depends on u8ks_pkg for the job type.
module u8ks_job_queue #(
   parameter int unsigned Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  u8ks_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output u8ks_pkg::job_type head_data
);
   import u8ks_pkg::*;

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastSlot = PtrW'(Depth - 1);

   job_type         slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   always_comb begin
      full       = (count_ff == CntW'(Depth));
      head_valid = (count_ff != '0);
      head_data  = slots_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/u8ks_back.sv]
// Back end of the decoder: walks a job one sequence or skipped byte at a time and emits keysym words.
// Depends on u8ks_pkg; reads jobs from u8ks_job_queue and owns the output register.
module u8ks_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  u8ks_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output u8ks_pkg::rsp_type rsp_data
);
   import u8ks_pkg::*;

   logic [2:0]      pos_ff, pos_in;
   rsp_type         held_ff, held_in;
   logic            held_valid_ff, held_valid_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [3:0][7:0] window;
   logic [1:0]      idx;
   logic [2:0]      len;
   logic [2:0]      avail;
   logic [2:0]      next_pos;
   logic [20:0]     cp;
   logic            at_end;
   logic            emit;
   logic            done;
   logic            out_free;
   logic            need_out;
   logic            send;
   rsp_type         send_word;
   rsp_type         new_word;

   // One step of the scan at the current position.
   always_comb begin
      idx = pos_ff[1:0];
      for (int k = 0; k < 4; k++) begin
         window[k] = job.bytes[idx + 2'(k)];
      end
      at_end   = (pos_ff >= job.count);
      len      = lead_length(window[0]);
      avail    = job.count - pos_ff;
      cp       = decode_cp(window, len);
      new_word = make_word(cp);
      emit     = 1'b0;
      done     = 1'b0;
      next_pos = pos_ff;
      if (at_end) begin
         done = 1'b1;
      end else if (len == 3'd0) begin
         next_pos = pos_ff + 3'd1;
      end else if (avail < len) begin
         // A truncated sequence at the end of a line: drop its lead and rescan.
         if (job.line_end) begin
            next_pos = pos_ff + 3'd1;
         end else begin
            done = 1'b1;
         end
      end else begin
         next_pos = pos_ff + len;
         emit     = (cp == TabCodePt) || (cp >= FirstPrint);
      end
      if (next_pos >= job.count) begin
         done = 1'b1;
      end
   end

   // A found word is held back until it is known whether another follows,
   // so that the last one of a job can carry run_last.
   always_comb begin
      out_free      = !rsp_valid_ff || rsp_pop;
      need_out      = (emit && (held_valid_ff || done)) || (!emit && done && held_valid_ff);
      pos_in        = pos_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      send          = 1'b0;
      send_word     = held_ff;
      job_pop       = 1'b0;
      if (job_valid && (!need_out || out_free)) begin
         if (emit && held_valid_ff) begin
            send               = 1'b1;
            send_word          = held_ff;
            send_word.run_last = 1'b0;
            held_in            = new_word;
            pos_in             = next_pos;
         end else if (emit && done) begin
            send               = 1'b1;
            send_word          = new_word;
            send_word.run_last = 1'b1;
            pos_in             = 3'd0;
            job_pop            = 1'b1;
         end else if (emit) begin
            held_in       = new_word;
            held_valid_in = 1'b1;
            pos_in        = next_pos;
         end else if (done) begin
            send               = held_valid_ff;
            send_word          = held_ff;
            send_word.run_last = 1'b1;
            held_valid_in      = 1'b0;
            pos_in             = 3'd0;
            job_pop            = 1'b1;
         end else begin
            pos_in = next_pos;
         end
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (send) begin
         rsp_in       = send_word;
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
      rsp_empty = !rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         pos_ff        <= 3'd0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

[src/u8ks_checker.sv]
// Port-level checks for the UTF-8 to keysym decoder, bound to its top level.
// Depends on u8ks_pkg and utf8_to_keysym_decoder.
module u8ks_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input u8ks_pkg::rsp_type rsp_data
);
   import u8ks_pkg::*;

   // Reset leaves no word waiting and room for input.
   a_reset_idle : assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("decoder not idle after reset");

   // A waiting word that is not taken stays unchanged.
   a_word_holds : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting word changed before it was taken");

   // The tab flag goes with the tab keysym and with nothing else.
   a_tab_match : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.tab_key == (rsp_data.keysym == TabKeysym))
      else $error("tab flag and keysym disagree");

   // Other words are printable Latin-1 or carry the Unicode marker bit.
   a_keysym_form : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.tab_key |->
         rsp_data.keysym[23:21] == 3'd0 &&
         ((rsp_data.keysym[24] && rsp_data.keysym[20:0] >= Latin1Limit) ||
          (!rsp_data.keysym[24] && rsp_data.keysym[20:0] >= FirstPrint &&
           rsp_data.keysym[20:0] < Latin1Limit)))
      else $error("keysym word out of form");

endmodule

bind utf8_to_keysym_decoder u8ks_checker u_checker (.*);
